### design/f1ots_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f1ots_pkg
// Shared types and constants of the F1 threshold search block.
// ----------------------------------------------------------------------------
package f1ots_pkg;

    // width of the ratio register and its reset value (1.5 in q8)
    localparam int RATIO_BITS = 16;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd384;

    // width of each count field in a result word
    localparam int OUT_COUNT_BITS = 32;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_SW_INIT,
        ST_CAND,
        ST_MUL_LOAD,
        ST_MUL,
        ST_DECIDE,
        ST_STEP,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_we;
        logic accept;
        logic upd;
        logic sw_init;
        logic cand;
        logic mul_load;
        logic decide;
        logic step;
        logic emit;
        logic sweep_addr;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last;
        logic mul_done;
        logic thr_gt_min;
        logic out_free;
        logic clr_done;
    } status_t;

endpackage

### design/f1ots_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f1ots_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module f1ots_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### design/f1ots_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f1ots_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module f1ots_mul #(
    parameter int W = 34
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] product,
    output logic           done
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic [CW-1:0]  cnt_reg;

    // iterate over the multiplier bits, lowest first
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else if (load) begin
            acc_reg    <= '0;
            mcand_reg  <= (2*W)'(a);
            mplier_reg <= b;
            cnt_reg    <= CW'(W);
        end else if (cnt_reg != '0) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg - 1'b1;
        end
    end

    assign product = acc_reg;
    assign done    = (cnt_reg == '0);

endmodule

### design/f1ots_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f1ots_ctrl
// Controller: histogram clear, item update, threshold sweep and result.
// ----------------------------------------------------------------------------
module f1ots_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  f1ots_pkg::status_t status,
    output f1ots_pkg::cmd_t    cmd
);

    f1ots_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= f1ots_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            f1ots_pkg::ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (status.clr_done) begin
                    state_next = f1ots_pkg::ST_IDLE;
                end
            end
            f1ots_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = f1ots_pkg::ST_UPD;
                end
            end
            f1ots_pkg::ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = status.last ? f1ots_pkg::ST_SW_INIT : f1ots_pkg::ST_IDLE;
            end
            f1ots_pkg::ST_SW_INIT: begin
                cmd.sw_init = 1'b1;
                state_next  = f1ots_pkg::ST_CAND;
            end
            f1ots_pkg::ST_CAND: begin
                cmd.cand   = 1'b1;
                state_next = f1ots_pkg::ST_MUL_LOAD;
            end
            f1ots_pkg::ST_MUL_LOAD: begin
                cmd.mul_load = 1'b1;
                state_next   = f1ots_pkg::ST_MUL;
            end
            f1ots_pkg::ST_MUL: begin
                if (status.mul_done) begin
                    state_next = f1ots_pkg::ST_DECIDE;
                end
            end
            f1ots_pkg::ST_DECIDE: begin
                cmd.decide     = 1'b1;
                cmd.sweep_addr = 1'b1;
                state_next = status.thr_gt_min ? f1ots_pkg::ST_STEP : f1ots_pkg::ST_EMIT;
            end
            f1ots_pkg::ST_STEP: begin
                cmd.step       = 1'b1;
                cmd.sweep_addr = 1'b1;
                state_next     = f1ots_pkg::ST_CAND;
            end
            f1ots_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = f1ots_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = f1ots_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

### design/f1ots_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f1ots_dp
// Datapath: histograms, statistics, sweep accumulators, F1 compare, output.
// ----------------------------------------------------------------------------
module f1ots_dp #(
    parameter int S = 12,
    parameter int C = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  f1ots_pkg::cmd_t                        cmd,
    output f1ots_pkg::status_t                     status,
    input  logic                                  cfg_we,
    input  logic [f1ots_pkg::RATIO_BITS-1:0]       cfg_wdata,
    input  logic [S-1:0]                          in_score,
    input  logic                                  in_pos,
    input  logic                                  in_last,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [S:0]                            out_thr,
    output logic [f1ots_pkg::OUT_COUNT_BITS-1:0]   out_tp,
    output logic [f1ots_pkg::OUT_COUNT_BITS-1:0]   out_fp,
    output logic [f1ots_pkg::OUT_COUNT_BITS-1:0]   out_fn,
    output logic                                  out_within,
    output logic                                  out_ovf
);

    localparam int NB  = 1 << S;
    localparam int TW  = S + 1;
    localparam int W   = C + 2;
    localparam int PW  = 2 * W;
    localparam int RPW = C + f1ots_pkg::RATIO_BITS;
    localparam int OCW = f1ots_pkg::OUT_COUNT_BITS;

    // latched item
    logic [S-1:0] idx_reg;
    logic         pos_reg;
    logic         last_reg;

    // data set statistics
    logic [S-1:0] min_reg, max_reg;
    logic [C-1:0] pos_total_reg;
    logic         sat_reg;
    logic [f1ots_pkg::RATIO_BITS-1:0] ratio_reg;
    logic [RPW-1:0] rp_reg;
    logic [S-1:0] clr_addr_reg;

    // sweep state
    logic [TW-1:0] thr_reg;
    logic [C-1:0]  tp_reg, fp_reg;

    // current candidate
    logic [C-1:0] cand_fn_reg;
    logic [W-1:0] cand_num_reg, cand_den_reg;
    logic         cand_allowed_reg;

    // best overall and best allowed
    logic          any_valid_reg, alw_valid_reg;
    logic [TW-1:0] any_thr_reg, alw_thr_reg;
    logic [C-1:0]  any_tp_reg, any_fp_reg, any_fn_reg;
    logic [C-1:0]  alw_tp_reg, alw_fp_reg, alw_fn_reg;
    logic [W-1:0]  any_num_reg, any_den_reg, alw_num_reg, alw_den_reg;

    // ram ports
    logic [S-1:0] in_idx, sweep_bin, raddr, waddr;
    logic [C-1:0] t_rdata, f_rdata, wdata;
    logic         t_we, f_we;

    // histogram update
    logic [C-1:0] hist_rd, hist_inc;
    logic         hist_sat;
    logic         tot_sat;

    // sweep accumulation
    logic [C:0]   tp_sum, fp_sum;
    logic [C-1:0] tp_next, fp_next;

    // candidate terms
    logic [C-1:0]   fn_c;
    logic [W-1:0]   num_c, den_c, num_sel, den_sel;
    logic [C:0]     pred;
    logic           allow_c;

    // products
    logic [PW-1:0] pa1, pa2, pb1, pb2;
    logic [3:0]    mdone;
    logic          any_upd, alw_upd;

    // output register
    logic            m_valid_reg;
    logic [TW-1:0]   sel_thr;

    // bin of a score: flip the sign bit
    assign in_idx    = {~in_score[S-1], in_score[S-2:0]};
    assign sweep_bin = S'(thr_reg - TW'(1));

    assign raddr = cmd.sweep_addr ? sweep_bin : in_idx;
    assign waddr = cmd.clr_we ? clr_addr_reg : (cmd.step ? sweep_bin : idx_reg);

    assign hist_rd  = pos_reg ? t_rdata : f_rdata;
    assign hist_sat = &hist_rd;
    assign hist_inc = hist_sat ? hist_rd : hist_rd + 1'b1;
    assign tot_sat  = pos_reg && (&pos_total_reg);

    assign wdata = (cmd.clr_we || cmd.step) ? '0 : hist_inc;
    assign t_we  = cmd.clr_we || cmd.step || (cmd.upd && pos_reg);
    assign f_we  = cmd.clr_we || cmd.step || (cmd.upd && !pos_reg);

    f1ots_ram #(.WIDTH(C), .DEPTH(NB)) u_true_ram (
        .clk(aclk), .we(t_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(t_rdata)
    );

    f1ots_ram #(.WIDTH(C), .DEPTH(NB)) u_false_ram (
        .clk(aclk), .we(f_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(f_rdata)
    );

    // saturating sweep sums
    assign tp_sum  = {1'b0, tp_reg} + {1'b0, t_rdata};
    assign fp_sum  = {1'b0, fp_reg} + {1'b0, f_rdata};
    assign tp_next = tp_sum[C] ? '1 : tp_sum[C-1:0];
    assign fp_next = fp_sum[C] ? '1 : fp_sum[C-1:0];

    // candidate f1 fraction and polyphony check
    assign fn_c  = (pos_total_reg >= tp_reg) ? pos_total_reg - tp_reg : '0;
    assign num_c = {1'b0, tp_reg, 1'b0};
    assign den_c = num_c + W'(fp_reg) + W'(fn_c);
    assign num_sel = (den_c == '0) ? '0 : num_c;
    assign den_sel = (den_c == '0) ? W'(1) : den_c;
    assign pred  = {1'b0, tp_reg} + {1'b0, fp_reg};
    assign allow_c = ({pred, 1'b0} >= W'(pos_total_reg)) &&
                     (RPW'({pred, 8'b0}) <= rp_reg);

    // cross products for the two comparisons
    f1ots_mul #(.W(W)) u_mul_a1 (
        .clk(aclk), .rst_n(aresetn), .load(cmd.mul_load),
        .a(cand_num_reg), .b(any_den_reg), .product(pa1), .done(mdone[0])
    );
    f1ots_mul #(.W(W)) u_mul_a2 (
        .clk(aclk), .rst_n(aresetn), .load(cmd.mul_load),
        .a(any_num_reg), .b(cand_den_reg), .product(pa2), .done(mdone[1])
    );
    f1ots_mul #(.W(W)) u_mul_b1 (
        .clk(aclk), .rst_n(aresetn), .load(cmd.mul_load),
        .a(cand_num_reg), .b(alw_den_reg), .product(pb1), .done(mdone[2])
    );
    f1ots_mul #(.W(W)) u_mul_b2 (
        .clk(aclk), .rst_n(aresetn), .load(cmd.mul_load),
        .a(alw_num_reg), .b(cand_den_reg), .product(pb2), .done(mdone[3])
    );

    // strictly better replaces, so ties keep the higher threshold
    assign any_upd = !any_valid_reg || (pa1 > pa2);
    assign alw_upd = cand_allowed_reg && (!alw_valid_reg || (pb1 > pb2));

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            pos_total_reg <= '0;
            sat_reg       <= 1'b0;
            any_valid_reg <= 1'b0;
            alw_valid_reg <= 1'b0;
            ratio_reg     <= f1ots_pkg::RATIO_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                ratio_reg <= cfg_wdata;
            end
            if (cmd.clr_we) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.upd) begin
                if (idx_reg < min_reg) begin
                    min_reg <= idx_reg;
                end
                if (idx_reg > max_reg) begin
                    max_reg <= idx_reg;
                end
                if (pos_reg && !tot_sat) begin
                    pos_total_reg <= pos_total_reg + 1'b1;
                end
                if (hist_sat || tot_sat) begin
                    sat_reg <= 1'b1;
                end
            end
            if (cmd.step && (tp_sum[C] || fp_sum[C])) begin
                sat_reg <= 1'b1;
            end
            if (cmd.decide) begin
                if (any_upd) begin
                    any_valid_reg <= 1'b1;
                end
                if (alw_upd) begin
                    alw_valid_reg <= 1'b1;
                end
            end
            if (cmd.emit) begin
                m_valid_reg   <= 1'b1;
                min_reg       <= '1;
                max_reg       <= '0;
                pos_total_reg <= '0;
                sat_reg       <= 1'b0;
                any_valid_reg <= 1'b0;
                alw_valid_reg <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sel_thr = alw_valid_reg ? alw_thr_reg : any_thr_reg;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg  <= in_idx;
            pos_reg  <= in_pos;
            last_reg <= in_last;
        end
        if (cmd.sw_init) begin
            thr_reg <= {1'b0, max_reg} + TW'(1);
            tp_reg  <= '0;
            fp_reg  <= '0;
            rp_reg  <= RPW'(ratio_reg) * RPW'(pos_total_reg);
        end
        if (cmd.step) begin
            thr_reg <= thr_reg - TW'(1);
            tp_reg  <= tp_next;
            fp_reg  <= fp_next;
        end
        if (cmd.cand) begin
            cand_fn_reg      <= fn_c;
            cand_num_reg     <= num_sel;
            cand_den_reg     <= den_sel;
            cand_allowed_reg <= allow_c;
        end
        if (cmd.decide) begin
            if (any_upd) begin
                any_thr_reg <= thr_reg;
                any_tp_reg  <= tp_reg;
                any_fp_reg  <= fp_reg;
                any_fn_reg  <= cand_fn_reg;
                any_num_reg <= cand_num_reg;
                any_den_reg <= cand_den_reg;
            end
            if (alw_upd) begin
                alw_thr_reg <= thr_reg;
                alw_tp_reg  <= tp_reg;
                alw_fp_reg  <= fp_reg;
                alw_fn_reg  <= cand_fn_reg;
                alw_num_reg <= cand_num_reg;
                alw_den_reg <= cand_den_reg;
            end
        end
        if (cmd.emit) begin
            out_thr    <= sel_thr - (TW'(1) << (S - 1));
            out_tp     <= OCW'(alw_valid_reg ? alw_tp_reg : any_tp_reg);
            out_fp     <= OCW'(alw_valid_reg ? alw_fp_reg : any_fp_reg);
            out_fn     <= OCW'(alw_valid_reg ? alw_fn_reg : any_fn_reg);
            out_within <= alw_valid_reg;
            out_ovf    <= sat_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    // status to the controller
    assign status.last       = last_reg;
    assign status.mul_done   = &mdone;
    assign status.thr_gt_min = thr_reg > {1'b0, min_reg};
    assign status.out_free   = !m_valid_reg || m_tready;
    assign status.clr_done   = &clr_addr_reg;

endmodule

### design/f1_optimal_threshold_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f1_optimal_threshold_search
// Histogram based threshold sweep that picks the threshold of best F1.
// ----------------------------------------------------------------------------
// Usage:
// - the s_ channel carries one score per word (tdata), its label (tuser)
//   and tlast on the final score of a data set
// - each score is read, then its histogram bin is incremented
// - on the last word the block sweeps from max+1 down to min; every
//   threshold goes through the bit-serial multipliers of the F1
//   cross-multiplication; bins are zeroed as they are read
// - one result word leaves on the m_ channel (tdata thr and counts, tuser flags)
// - after reset a clearing pass over all 2^SCORE_BITS bins zeroes both
//   histograms; no word is taken during it, cfg_we writes still land
// - the result sits in an output register; new scores are taken while it
//   waits, and a following result waits until m_tready frees the register
// - cfg_we/cfg_wdata write the polyphony ratio (q8); reset value is 1.5
// ----------------------------------------------------------------------------
module f1_optimal_threshold_search #(
    parameter int SCORE_BITS = 12,
    parameter int COUNT_BITS = 32
) (
    input  logic aclk,
    input  logic aresetn,
    // ratio register
    input  logic                                cfg_we,
    input  logic [f1ots_pkg::RATIO_BITS-1:0]     cfg_wdata,
    // score input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SCORE_BITS+7)/8)*8-1:0]      s_tdata,  // score
    input  logic                                s_tuser,  // is_positive
    input  logic                                s_tlast,  // last_item
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // best_threshold, true_pos, false_pos, false_neg
    output logic [((SCORE_BITS+1+3*f1ots_pkg::OUT_COUNT_BITS+7)/8)*8-1:0] m_tdata,
    output logic [1:0]                          m_tuser   // within_limits, overflow_flag
);

    localparam int OW = ((SCORE_BITS + 1 + 3 * f1ots_pkg::OUT_COUNT_BITS + 7) / 8) * 8;
    localparam int OCW = f1ots_pkg::OUT_COUNT_BITS;

    f1ots_pkg::cmd_t    cmd;
    f1ots_pkg::status_t status;

    logic [SCORE_BITS:0] out_thr;
    logic [OCW-1:0]      out_tp, out_fp, out_fn;
    logic                out_within, out_ovf;

    // controller
    f1ots_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .status(status), .cmd(cmd)
    );

    // datapath
    f1ots_dp #(.S(SCORE_BITS), .C(COUNT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_score(s_tdata[SCORE_BITS-1:0]), .in_pos(s_tuser), .in_last(s_tlast),
        .m_tready(m_tready), .m_tvalid(m_tvalid),
        .out_thr(out_thr), .out_tp(out_tp), .out_fp(out_fp), .out_fn(out_fn),
        .out_within(out_within), .out_ovf(out_ovf)
    );

    // pack the result word
    assign m_tdata = OW'({out_fn, out_fp, out_tp, out_thr});
    assign m_tuser = {out_ovf, out_within};

endmodule

### dv/f1_optimal_threshold_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f1_optimal_threshold_search_tb
// Self-checking bench for the best-F1 threshold search. Score words stream
// in as small data sets; a local histogram sweep or a directed table row
// gives the expected threshold and counts of each tlast word, and every
// result word is compared field by field. The table comes first, then random
// data sets under several ratio settings and idle patterns on both sides.
// ----------------------------------------------------------------------------
module f1_optimal_threshold_search_tb;

    localparam int SB       = 12;
    localparam int NBINS    = 1 << SB;
    localparam int HALF     = 1 << (SB - 1);
    localparam int LIMIT    = 1000000;
    localparam int HOLD_LEN = 20000;
    localparam longint unsigned CMAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic signed [SB:0] thr;
        logic [31:0]        tp;
        logic [31:0]        fp;
        logic [31:0]        fn;
        logic               in_limits;
        logic               ovf;
    } f1_res_t;

    typedef struct {
        bit              ok;
        int unsigned     idx;
        longint unsigned tp;
        longint unsigned fp;
        longint unsigned fn;
    } pick_t;

    typedef struct {
        int      score;
        bit      pos;
        bit      last;
        bit      typed;
        f1_res_t res;
    } row_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [f1ots_pkg::RATIO_BITS-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [15:0] s_tdata;   // score
    logic s_tuser;          // is_positive
    logic s_tlast;          // last_item
    logic m_tvalid;
    logic m_tready;
    logic [111:0] m_tdata;  // best_threshold, true_pos, false_pos, false_neg
    logic [1:0] m_tuser;    // within_limits, overflow_flag

    f1_optimal_threshold_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // predictor state
    longint unsigned pos_hist[NBINS];
    longint unsigned neg_hist[NBINS];
    int unsigned lo_bin, hi_bin;
    longint unsigned pos_total;
    bit sat_flag;
    logic [f1ots_pkg::RATIO_BITS-1:0] ratio_q8;

    f1_res_t results_due[$];
    int errors;
    int pct_s, pct_r;
    bit hold_req;
    bit typed_q[$];
    f1_res_t typed_res_q[$];

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // count add that stops at the counter maximum
    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        if (s > CMAX) begin
            sat_flag = 1;
            return CMAX;
        end
        return s;
    endfunction

    function automatic bit f1_beats(pick_t c, pick_t b);
        longint unsigned nc, dc, nb, db;
        logic [127:0] lhs, rhs;
        if (!b.ok) return 1;
        nc = 2 * c.tp;
        dc = 2 * c.tp + c.fp + c.fn;
        if (dc == 0) begin
            nc = 0;
            dc = 1;
        end
        nb = 2 * b.tp;
        db = 2 * b.tp + b.fp + b.fn;
        if (db == 0) begin
            nb = 0;
            db = 1;
        end
        lhs = 128'(nc) * 128'(db);
        rhs = 128'(nb) * 128'(dc);
        return lhs > rhs;
    endfunction

    function automatic void clear_hist();
        for (int i = 0; i < NBINS; i++) begin
            pos_hist[i] = 0;
            neg_hist[i] = 0;
        end
        lo_bin = NBINS - 1;
        hi_bin = 0;
        pos_total = 0;
        sat_flag = 0;
    endfunction

    // count one word; on tlast sweep downward and return the best pick
    function automatic bit count_and_sweep(logic [SB-1:0] score, bit pos, bit last,
                                           output f1_res_t r);
        int unsigned idx;
        longint unsigned tp, fp, pred;
        pick_t c, best_ok, best_all, w;
        idx = int'(score) ^ HALF;
        if (pos) begin
            pos_hist[idx] = sat_add(pos_hist[idx], 1);
            pos_total = sat_add(pos_total, 1);
        end else begin
            neg_hist[idx] = sat_add(neg_hist[idx], 1);
        end
        if (idx < lo_bin) lo_bin = idx;
        if (idx > hi_bin) hi_bin = idx;
        if (!last) return 0;
        tp = 0;
        fp = 0;
        best_ok = '{default: 0};
        best_all = '{default: 0};
        for (int t = int'(hi_bin) + 1; t >= int'(lo_bin); t--) begin
            if (t <= int'(hi_bin)) begin
                tp = sat_add(tp, pos_hist[t]);
                fp = sat_add(fp, neg_hist[t]);
            end
            c.ok = 1;
            c.idx = t;
            c.tp = tp;
            c.fp = fp;
            c.fn = (pos_total >= tp) ? pos_total - tp : 0;
            pred = tp + fp;
            if (f1_beats(c, best_all)) best_all = c;
            if (2 * pred >= pos_total && pred * 256 <= longint'(ratio_q8) * pos_total &&
                f1_beats(c, best_ok)) best_ok = c;
        end
        w = best_ok.ok ? best_ok : best_all;
        r.thr = 13'(w.idx) - 13'(HALF);
        r.tp = w.tp[31:0];
        r.fp = w.fp[31:0];
        r.fn = w.fn[31:0];
        r.in_limits = best_ok.ok;
        r.ovf = sat_flag;
        clear_hist();
        return 1;
    endfunction

    // input monitor feeds the predictor
    always @(posedge aclk) begin
        f1_res_t r, tres;
        bit typed;
        if (aresetn && s_tvalid && s_tready) begin
            typed = 0;
            tres = '0;
            if (typed_q.size() != 0) begin
                typed = typed_q.pop_front();
                tres = typed_res_q.pop_front();
            end
            if (count_and_sweep(s_tdata[SB-1:0], s_tuser, s_tlast, r))
                results_due.push_back(typed ? tres : r);
        end
    end

    // result checker
    always @(posedge aclk) begin
        f1_res_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.thr = m_tdata[12:0];
            got.tp = m_tdata[44:13];
            got.fp = m_tdata[76:45];
            got.fn = m_tdata[108:77];
            got.in_limits = m_tuser[0];
            got.ovf = m_tuser[1];
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result word thr=%0d", $time, got.thr);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    $display("%0t: expected thr=%0d tp=%0d fp=%0d fn=%0d within=%0d ovf=%0d",
                             $time, want.thr, want.tp, want.fp, want.fn, want.in_limits,
                             want.ovf);
                    $display("%0t: actual   thr=%0d tp=%0d fp=%0d fn=%0d within=%0d ovf=%0d",
                             $time, got.thr, got.tp, got.fp, got.fn, got.in_limits, got.ovf);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet == LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver with random backpressure and one long hold
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_cnt = HOLD_LEN;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(99) >= pct_r);
            end
        end
    end

    // drive one word, with random gaps before it
    task automatic send_word(int score, bit pos, bit last);
        @(negedge aclk);
        while ($urandom_range(99) < pct_s) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, 12'(score)};
        s_tuser <= pos;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_ratio(logic [f1ots_pkg::RATIO_BITS-1:0] v);
        @(negedge aclk);
        s_tvalid <= 0;
        wait (results_due.size() == 0);
        repeat (20) @(negedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        ratio_q8 = v;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // random data set: labels pull scores about a center; uniform if wide
    task automatic send_set(bit wide, output int count);
        int n, center, spread, off, s;
        bit pos;
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        center = $urandom_range(NBINS - 1) - HALF;
        spread = $urandom_range(10);
        for (int i = 0; i < n; i++) begin
            pos = $urandom_range(1);
            if (wide) begin
                s = $urandom_range(NBINS - 1) - HALF;
            end else begin
                off = $urandom_range(spread);
                s = center + (pos ? off : -off) + $urandom_range(2) - 1;
                if (s < -HALF) s = -HALF;
                if (s > HALF - 1) s = HALF - 1;
            end
            send_word(s, pos, i == n - 1);
        end
        count = n;
    endtask

    row_t table_rows[$] = '{
        '{5, 1, 1, 1, '{13'sd5, 32'd1, 32'd0, 32'd0, 1'b1, 1'b0}},
        '{-2048, 1, 1, 1, '{-13'sd2048, 32'd1, 32'd0, 32'd0, 1'b1, 1'b0}},
        '{2047, 1, 1, 1, '{13'sd2047, 32'd1, 32'd0, 32'd0, 1'b1, 1'b0}},
        '{2047, 0, 1, 1, '{13'sd2048, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0}},
        '{-3, 0, 0, 0, '{default: 0}},
        '{0, 1, 0, 0, '{default: 0}},
        '{1, 0, 0, 0, '{default: 0}},
        '{4, 1, 1, 0, '{default: 0}},
        '{7, 1, 0, 0, '{default: 0}},
        '{7, 1, 0, 0, '{default: 0}},
        '{7, 0, 1, 0, '{default: 0}},
        '{10, 0, 0, 0, '{default: 0}},
        '{-1, 0, 1, 0, '{default: 0}},
        '{0, 0, 0, 0, '{default: 0}},
        '{0, 0, 0, 0, '{default: 0}},
        '{0, 0, 0, 0, '{default: 0}},
        '{1, 1, 1, 0, '{default: 0}},
        '{-2048, 1, 0, 0, '{default: 0}},
        '{2047, 0, 1, 0, '{default: 0}}
    };

    // main sequence
    initial begin
        logic [f1ots_pkg::RATIO_BITS-1:0] ratios[6];
        int items;
        int cnt;
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        s_tlast = 0;
        errors = 0;
        hold_req = 0;
        ratio_q8 = f1ots_pkg::RATIO_RESET;
        clear_hist();
        pct_s = 17;
        pct_r = 48;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed table under the reset ratio
        foreach (table_rows[i]) begin
            typed_q.push_back(table_rows[i].typed);
            typed_res_q.push_back(table_rows[i].res);
            send_word(table_rows[i].score, table_rows[i].pos, table_rows[i].last);
        end

        ratios = '{16'd128, 16'd65535, 16'd0, 16'($urandom_range(128, 65535)),
                   16'($urandom_range(100, 1000)), f1ots_pkg::RATIO_RESET};
        for (int ph = 0; ph < 6; ph++) begin
            write_ratio(ratios[ph]);
            pct_s = (ph < 2) ? 17 : (ph < 4) ? 48 : 0;
            pct_r = (ph < 2) ? 48 : (ph < 4) ? 17 : 0;
            if (ph == 1) hold_req = 1;
            items = 0;
            if (ph == 4) begin
                send_set(1, cnt);
                items = items + cnt;
            end
            while (items < 330) begin
                send_set(0, cnt);
                items = items + cnt;
            end
        end
        @(negedge aclk);
        s_tvalid <= 0;

        wait (results_due.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
